@@ hdl/iiht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiht_pkg
// types and codes shared by the identifier intern hash table modules
// ----------------------------------------------------------------------------
package iiht_pkg;

  // actions
  localparam logic [1:0] ACT_GET_OR_ADD = 2'd0;
  localparam logic [1:0] ACT_GET_ONLY   = 2'd1;
  localparam logic [1:0] ACT_KEY_ONLY   = 2'd2;
  localparam logic [1:0] ACT_KEY_PTR    = 2'd3;

  // configuration register indexes
  localparam logic CFG_LENGTH_SHIFT = 1'b0;
  localparam logic CFG_SLOT_LOG2    = 1'b1;

  localparam int unsigned PTR_BIAS = 4;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_ADDED     = 3'd1,
    ST_NOTFOUND  = 3'd2,
    ST_TABLEFULL = 3'd3,
    ST_STOREFULL = 3'd4,
    ST_BADKEY    = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
    logic [7:0]  id_char;
    logic        char_valid;
    logic [15:0] query_pointer;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] pointer;
    logic [9:0]  slot_index;
    logic [9:0]  entries_used;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    take_item;
    logic    init_probe;
    logic    next_slot;
    logic    start_cmp;
    logic    inc_i;
    logic    start_add;
    logic    wr_add;
    logic    commit;
    logic    clear_step;
    logic    set_result;
    status_e res_status;
    logic    finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       bad;
    logic       exhausted;
    logic       empty;
    logic       key_eq;
    logic       ptr_eq;
    logic       store_ok;
    logic       range_ok;
    logic       cmp_done;
    logic       byte_eq;
    logic       add_done;
    logic       clear_done;
  } stat_t;

endpackage

@@ hdl/iiht_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiht_ctrl
// sequencer for clearing, probing, string compare and string append
// ----------------------------------------------------------------------------
module iiht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           item_last_i,
  input  iiht_pkg::stat_t stat_i,
  output iiht_pkg::cmd_t  cmd_o,
  output logic           busy,
  output logic           result_valid_o
);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_CHECK  = 11'b000_0000_0100,
    S_PROBE  = 11'b000_0000_1000,
    S_SLOT   = 11'b000_0001_0000,
    S_CMP_RD = 11'b000_0010_0000,
    S_CMP_EV = 11'b000_0100_0000,
    S_ADD_RD = 11'b000_1000_0000,
    S_ADD_WR = 11'b001_0000_0000,
    S_COMMIT = 11'b010_0000_0000,
    S_RESULT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.res_status = iiht_pkg::ST_NOTFOUND;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.take_item = 1'b1;
          if (item_last_i) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.bad) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = iiht_pkg::ST_BADKEY;
          state_d = S_RESULT;
        end else begin
          cmd_o.init_probe = 1'b1;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat_i.exhausted) begin
          cmd_o.set_result = 1'b1;
          if (stat_i.action == iiht_pkg::ACT_GET_OR_ADD) begin
            cmd_o.res_status = iiht_pkg::ST_TABLEFULL;
          end else begin
            cmd_o.res_status = iiht_pkg::ST_NOTFOUND;
          end
          state_d = S_RESULT;
        end else begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        if (stat_i.empty) begin
          if (stat_i.action == iiht_pkg::ACT_GET_OR_ADD) begin
            if (stat_i.store_ok) begin
              cmd_o.start_add = 1'b1;
              state_d = S_ADD_RD;
            end else begin
              cmd_o.set_result = 1'b1;
              cmd_o.res_status = iiht_pkg::ST_STOREFULL;
              state_d = S_RESULT;
            end
          end else begin
            cmd_o.set_result = 1'b1;
            cmd_o.res_status = iiht_pkg::ST_NOTFOUND;
            state_d = S_RESULT;
          end
        end else if (stat_i.key_eq &&
                     (stat_i.action == iiht_pkg::ACT_KEY_ONLY ||
                      (stat_i.action == iiht_pkg::ACT_KEY_PTR && stat_i.ptr_eq))) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = iiht_pkg::ST_FOUND;
          state_d = S_RESULT;
        end else if (stat_i.key_eq && stat_i.range_ok &&
                     (stat_i.action == iiht_pkg::ACT_GET_OR_ADD ||
                      stat_i.action == iiht_pkg::ACT_GET_ONLY)) begin
          cmd_o.start_cmp = 1'b1;
          state_d = S_CMP_RD;
        end else begin
          cmd_o.next_slot = 1'b1;
          state_d = S_PROBE;
        end
      end
      S_CMP_RD: begin
        if (stat_i.cmp_done) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = iiht_pkg::ST_FOUND;
          state_d = S_RESULT;
        end else begin
          state_d = S_CMP_EV;
        end
      end
      S_CMP_EV: begin
        if (stat_i.byte_eq) begin
          cmd_o.inc_i = 1'b1;
          state_d = S_CMP_RD;
        end else begin
          cmd_o.next_slot = 1'b1;
          state_d = S_PROBE;
        end
      end
      S_ADD_RD: begin
        state_d = stat_i.add_done ? S_COMMIT : S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.wr_add = 1'b1;
        state_d = S_ADD_RD;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        cmd_o.set_result = 1'b1;
        cmd_o.res_status = iiht_pkg::ST_ADDED;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign busy = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RESULT);

endmodule

@@ hdl/iiht_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiht_dp
// slot table, string store, character buffer and probe registers
// ----------------------------------------------------------------------------
module iiht_dp #(
  parameter int unsigned MAX_SLOT_LOG2 = 10,
  parameter int unsigned STRING_BYTES  = 32768,
  parameter int unsigned MAX_LENGTH    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [4:0]        cfg_data_i,
  input  iiht_pkg::item_t   item_i,
  input  iiht_pkg::cmd_t    cmd_i,
  output iiht_pkg::stat_t   stat_o,
  output iiht_pkg::result_t result_o
);

  localparam int unsigned AW    = MAX_SLOT_LOG2;
  localparam int unsigned SLOTS = 1 << AW;
  localparam int unsigned SW    = $clog2(STRING_BYTES);
  localparam int unsigned CW    = $clog2(MAX_LENGTH + 2);
  localparam int unsigned BW    = $clog2(MAX_LENGTH);
  localparam int unsigned IW    = $clog2(MAX_LENGTH + 5);

  logic [31:0] key_mem [SLOTS];
  logic [15:0] ptr_mem [SLOTS];
  logic [7:0]  str_mem [STRING_BYTES];
  logic [7:0]  cb_mem  [MAX_LENGTH];

  logic [4:0]    shift_q;
  logic [3:0]    lg_q;
  logic [1:0]    action_q;
  logic [31:0]   key_q;
  logic [15:0]   qptr_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] len_q;
  logic [AW-1:0] idx_q, n_q, mask_q, clr_q;
  logic [AW:0]   filled_q;
  logic [SW-1:0] fill_q, base_q;
  logic [IW-1:0] i_q;
  logic [31:0]   sk_q;
  logic [15:0]   sp_q;
  logic [7:0]    str_rd_q, cb_rd_q;
  logic [2:0]    res_status_q;
  logic [15:0]   res_ptr_q;
  logic [AW-1:0] res_idx_q;

  logic [31:0]   len_full;
  logic [3:0]    lg_c;
  logic [AW-1:0] mask_c;
  logic [IW-1:0] need;
  logic [31:0]   p32, b32;
  logic          key_wr;
  logic [AW-1:0] key_wa;

  always_comb begin
    lg_c = lg_q;
    if (lg_q == 4'd0) lg_c = 4'd1;
    if (32'(lg_q) > MAX_SLOT_LOG2) lg_c = 4'(MAX_SLOT_LOG2);
  end
  assign mask_c   = AW'((32'd1 << lg_c) - 32'd1);
  assign len_full = key_q >> shift_q;
  assign need     = (IW'(len_q) + IW'(4)) & ~IW'(3);
  assign p32      = 32'(sp_q);
  assign b32      = p32 - 32'(iiht_pkg::PTR_BIAS);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 5'd20;
      lg_q    <= 4'd10;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        iiht_pkg::CFG_LENGTH_SHIFT: shift_q <= cfg_data_i;
        iiht_pkg::CFG_SLOT_LOG2:    lg_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      fill_q   <= '0;
      filled_q <= '0;
      clr_q    <= '0;
    end else begin
      if (cmd_i.take_item && item_i.char_valid && 32'(count_q) <= MAX_LENGTH)
        count_q <= count_q + CW'(1);
      if (cmd_i.finish) count_q <= '0;
      if (cmd_i.clear_step) clr_q <= clr_q + AW'(1);
      if (cmd_i.commit) begin
        fill_q   <= fill_q + SW'(need);
        filled_q <= filled_q + (AW+1)'(1);
      end
    end
  end

  // operation and probe registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && item_i.last) begin
      action_q <= item_i.action;
      key_q    <= item_i.key;
      qptr_q   <= item_i.query_pointer;
    end
    if (cmd_i.init_probe) begin
      len_q  <= CW'(len_full);
      mask_q <= mask_c;
      idx_q  <= key_q[AW-1:0] & mask_c;
      n_q    <= '0;
    end
    if (cmd_i.next_slot) begin
      idx_q <= (idx_q + AW'(1)) & mask_q;
      n_q   <= n_q + AW'(1);
    end
    if (cmd_i.start_cmp) base_q <= SW'(b32);
    if (cmd_i.start_cmp || cmd_i.start_add) i_q <= '0;
    if (cmd_i.inc_i || cmd_i.wr_add) i_q <= i_q + IW'(1);
    if (cmd_i.set_result) begin
      res_status_q <= cmd_i.res_status;
      if (cmd_i.res_status == iiht_pkg::ST_FOUND) begin
        res_ptr_q <= sp_q;
        res_idx_q <= idx_q;
      end else if (cmd_i.res_status == iiht_pkg::ST_ADDED) begin
        res_ptr_q <= 16'(32'(fill_q) + 32'(iiht_pkg::PTR_BIAS));
        res_idx_q <= idx_q;
      end else begin
        res_ptr_q <= '0;
        res_idx_q <= '0;
      end
    end
  end

  // slot table
  assign key_wr = cmd_i.clear_step || cmd_i.commit;
  assign key_wa = cmd_i.clear_step ? clr_q : idx_q;
  always_ff @(posedge clk_i) begin
    if (key_wr) key_mem[key_wa] <= cmd_i.clear_step ? 32'd0 : key_q;
    if (cmd_i.commit) ptr_mem[idx_q] <= 16'(32'(fill_q) + 32'(iiht_pkg::PTR_BIAS));
    sk_q <= key_mem[idx_q];
    sp_q <= ptr_mem[idx_q];
  end

  // string store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_add)
      str_mem[fill_q + SW'(i_q)] <= (32'(i_q) < 32'(len_q)) ? cb_rd_q : 8'h00;
    str_rd_q <= str_mem[base_q + SW'(i_q)];
  end

  // character buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && item_i.char_valid && 32'(count_q) < MAX_LENGTH)
      cb_mem[count_q[BW-1:0]] <= item_i.id_char;
    cb_rd_q <= cb_mem[i_q[BW-1:0]];
  end

  always_comb begin
    stat_o.action     = action_q;
    stat_o.bad        = (key_q == 32'd0) ||
                        (action_q <= iiht_pkg::ACT_GET_ONLY &&
                         (len_full > 32'(MAX_LENGTH) || len_full != 32'(count_q)));
    stat_o.exhausted  = (n_q == mask_q);
    stat_o.empty      = (sk_q == 32'd0);
    stat_o.key_eq     = (sk_q == key_q);
    stat_o.ptr_eq     = (sp_q == qptr_q);
    stat_o.store_ok   = (32'(fill_q) + 32'(need)) < 32'(STRING_BYTES);
    stat_o.range_ok   = (p32 >= 32'(iiht_pkg::PTR_BIAS)) && (b32 < 32'(STRING_BYTES)) &&
                        (32'(len_q) <= 32'(STRING_BYTES) - b32);
    stat_o.cmp_done   = (32'(i_q) == 32'(len_q));
    stat_o.byte_eq    = (str_rd_q == cb_rd_q);
    stat_o.add_done   = (i_q == need);
    stat_o.clear_done = (clr_q == {AW{1'b1}});
  end

  assign result_o.status       = res_status_q;
  assign result_o.pointer      = res_ptr_q;
  assign result_o.slot_index   = 10'(res_idx_q);
  assign result_o.entries_used = (32'(filled_q) > 32'd1023) ? 10'd1023 : 10'(filled_q);

endmodule

@@ hdl/identifier_intern_hash_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identifier_intern_hash_table_top
// interns identifiers in a linear-probing slot table with a byte string store
// ----------------------------------------------------------------------------
// a transfer is taken when start is high and busy is low; one character per
// transfer, and the transfer with last set runs the lookup and gives exactly
// one result, shown for one cycle with result_valid_o; the receiver cannot
// stall, so it must take the result in that cycle. after reset the block
// clears every entry of its slot table with busy high. with last, the
// lookup probes slots and compares stored strings character by character,
// and an add stores length+1 bytes rounded up to a multiple of 4; the slot
// and string memories have registered reads.
// configuration writes land at once and must only be made while idle
module identifier_intern_hash_table_top #(
  parameter int unsigned MAX_SLOT_LOG2 = 10,
  parameter int unsigned STRING_BYTES  = 32768,
  parameter int unsigned MAX_LENGTH    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command side
  input  logic              start,
  output logic              busy,
  input  iiht_pkg::item_t   item_i,
  // result side
  output logic              result_valid_o,
  output iiht_pkg::result_t result_o,
  // config write port
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [4:0]        cfg_data_i
);

  iiht_pkg::cmd_t  cmd;
  iiht_pkg::stat_t stat;

  // sequencer
  iiht_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_last_i    (item_i.last),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // memories and probe datapath
  iiht_dp #(
    .MAX_SLOT_LOG2 (MAX_SLOT_LOG2),
    .STRING_BYTES  (STRING_BYTES),
    .MAX_LENGTH    (MAX_LENGTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o)
  );

endmodule
